@@ rtl/blecw_pkg.sv @@
// Shared types, constants and bit-level helpers for the BLE CRC/whitening encoder.
package blecw_pkg;

  localparam int          MAX_PACKET_DEF  = 32;
  localparam int          CNT_W           = 6;
  localparam logic [23:0] CRC_POLY        = 24'h00065B;
  localparam logic [7:0]  WHITEN_TAPS     = 8'h11;
  localparam logic [7:0]  SEED_OR         = 8'h02;
  localparam logic [5:0]  CHANNEL_RESET   = 6'd37;
  localparam logic [23:0] CRC_INIT_RESET  = 24'h555555;

  typedef enum logic [0:0] {
    REG_CHANNEL  = 1'b0,
    REG_CRC_INIT = 1'b1
  } cfg_reg_t;

  // One queued command: the byte and how the back end must treat it.
  typedef struct packed {
    logic [7:0] data;
    logic       keep;   // data byte is encoded and emitted
    logic       last;   // CRC tail follows
    logic       start;  // first byte of a packet, reload CRC and whitener
    logic       ovf;    // overflow flag carried on the CRC bytes
  } cmd_t;

  typedef struct packed {
    logic [7:0] lfsr;
    logic [7:0] data;
  } wht_t;

  function automatic logic [7:0] rev8(input logic [7:0] x);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[i] = x[7-i];
    end
    return r;
  endfunction

  function automatic logic [7:0] seed_of(input logic [5:0] ch);
    return rev8({2'b00, ch}) | SEED_OR;
  endfunction

  // Eight CRC-24 steps, data LSB first.
  function automatic logic [23:0] crc_feed(input logic [23:0] crc, input logic [7:0] d);
    logic [23:0] c;
    logic        top;
    c = crc;
    for (int i = 0; i < 8; i++) begin
      top = c[23];
      c   = {c[22:0], 1'b0};
      if (top != d[i]) begin
        c = c ^ CRC_POLY;
      end
    end
    return c;
  endfunction

  // Eight whitening steps, data LSB first.
  function automatic wht_t whiten(input logic [7:0] lfsr, input logic [7:0] d);
    wht_t r;
    r.lfsr = lfsr;
    r.data = d;
    for (int i = 0; i < 8; i++) begin
      if (r.lfsr[7]) begin
        r.lfsr    = r.lfsr ^ WHITEN_TAPS;
        r.data[i] = ~r.data[i];
      end
      r.lfsr = {r.lfsr[6:0], 1'b0};
    end
    return r;
  endfunction

endpackage

@@ rtl/ble_adv_packet_crc_whiten_core.sv @@
// Top level of the BLE advertising CRC-24 and whitening encoder.
//
//  channel | direction | beat contents
//  --------+-----------+---------------------------------------------------
//  in_     | slave     | tdata = PDU byte, tlast = final PDU byte
//  out_    | master    | tdata = encoded byte, tuser = {overflow, is_crc},
//          |           | tlast = final CRC byte of the packet
//  cfg_    | write     | index 0 = channel_index, index 1 = crc_init
//
// Each input beat is accepted while the two-entry queue has room;
// a dropped byte without the last mark is accepted but never queued.
// The back end emits one output beat per cycle while the queue holds a command and
// the receiver is ready: one for a kept data byte, plus three CRC beats after a last
// byte, so a packet of N kept bytes gives N+3 beats from the single back-end encode
// step that runs the eight-step CRC and LFSR, via the queue and the output register.
// Reset is synchronous and active low; no clearing pass is needed after it.
// Either side may stall freely: the queue and the output register decouple them.
module ble_adv_packet_crc_whiten_core #(
  parameter int MAX_PACKET = blecw_pkg::MAX_PACKET_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // in_tdata: [7:0] data_byte
  input  logic [7:0]  in_tdata,
  input  logic        in_tlast,
  input  logic        in_tvalid,
  output logic        in_tready,
  // out_tdata: [7:0] out_byte
  output logic [7:0]  out_tdata,
  // out_tuser: [0] is_crc, [1] overflow
  output logic [1:0]  out_tuser,
  output logic        out_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  input  logic        cfg_wr_en,
  input  logic [0:0]  cfg_index,
  input  logic [23:0] cfg_wdata
);
  import blecw_pkg::*;

  logic [5:0]  channel_r;
  logic [23:0] crc_init_r;
  logic        push, pop, q_not_full, q_not_empty;
  cmd_t        push_cmd, head;
  logic        out_crc, out_ovf;

  // Configuration registers; the back end samples them at each packet start.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      channel_r  <= CHANNEL_RESET;
      crc_init_r <= CRC_INIT_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_CHANNEL:  channel_r  <= cfg_wdata[5:0];
        REG_CRC_INIT: crc_init_r <= cfg_wdata;
      endcase
    end
  end

  // Front end tracks the byte count and overflow, and decides what each byte means.
  blecw_front #(.MAX_PACKET(MAX_PACKET)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_data  (in_tdata),
    .in_last  (in_tlast),
    .q_ready  (q_not_full),
    .in_ready (in_tready),
    .push     (push),
    .cmd      (push_cmd)
  );

  blecw_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_cmd  (push_cmd),
    .pop       (pop),
    .not_full  (q_not_full),
    .not_empty (q_not_empty),
    .head      (head)
  );

  // Back end walks each command through its data step and CRC tail.
  blecw_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_not_empty),
    .head      (head),
    .channel   (channel_r),
    .crc_init  (crc_init_r),
    .out_ready (out_tready),
    .pop       (pop),
    .out_valid (out_tvalid),
    .out_byte  (out_tdata),
    .out_crc   (out_crc),
    .out_last  (out_tlast),
    .out_ovf   (out_ovf)
  );

  assign out_tuser = {out_ovf, out_crc};

endmodule

@@ rtl/blecw_front.sv @@
// Front end: accepts PDU beats, counts bytes and classifies each one.
module blecw_front #(
  parameter int MAX_PACKET = blecw_pkg::MAX_PACKET_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [7:0]       in_data,
  input  logic             in_last,
  input  logic             q_ready,
  output logic             in_ready,
  output logic             push,
  output blecw_pkg::cmd_t  cmd
);
  import blecw_pkg::*;

  localparam logic [CNT_W-1:0] LIMIT = CNT_W'(MAX_PACKET - 3);

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             ovf_r, ovf_nxt;
  logic             keep;
  logic             accept;

  // A dropped byte without the last mark is taken and marks overflow here but never
  // queued, since the back end has nothing to emit for it.
  assign in_ready = q_ready;
  assign accept   = in_valid && q_ready;
  assign push     = accept && (keep || in_last);
  assign keep     = cnt_r < LIMIT;

  always_comb begin
    cmd.data  = in_data;
    cmd.keep  = keep;
    cmd.last  = in_last;
    cmd.start = (cnt_r == '0);
    cmd.ovf   = ovf_r || !keep;
  end

  always_comb begin
    cnt_nxt = cnt_r;
    ovf_nxt = ovf_r;
    if (accept) begin
      priority if (in_last) begin
        cnt_nxt = '0;
        ovf_nxt = 1'b0;
      end else if (keep) begin
        cnt_nxt = cnt_r + 1'b1;
      end else begin
        ovf_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      ovf_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      ovf_r <= ovf_nxt;
    end
  end

endmodule

@@ rtl/blecw_fifo.sv @@
// Two-entry command queue between the front and back ends.
module blecw_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  blecw_pkg::cmd_t  push_cmd,
  input  logic             pop,
  output logic             not_full,
  output logic             not_empty,
  output blecw_pkg::cmd_t  head
);
  import blecw_pkg::*;

  cmd_t       mem [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r;

  assign not_full  = (cnt_r != 2'd2);
  assign not_empty = (cnt_r != 2'd0);
  assign head      = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

@@ rtl/blecw_back.sv @@
// Back end: runs CRC and whitening per command and drives the output register.
module blecw_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_valid,
  input  blecw_pkg::cmd_t  head,
  input  logic [5:0]       channel,
  input  logic [23:0]      crc_init,
  input  logic             out_ready,
  output logic             pop,
  output logic             out_valid,
  output logic [7:0]       out_byte,
  output logic             out_crc,
  output logic             out_last,
  output logic             out_ovf
);
  import blecw_pkg::*;

  logic [23:0] crc_r, crc_nxt, crc_cur;
  logic [7:0]  wh_r, wh_cur;
  logic [1:0]  step_r, k;
  logic        out_valid_r;
  logic [7:0]  byte_r;
  logic        crc_flag_r, last_r, ovf_r;
  logic        adv, is_data, done;
  logic [7:0]  crc_byte, enc_byte;
  wht_t        w;

  assign adv     = q_valid && (!out_valid_r || out_ready);
  assign crc_cur = (head.start && step_r == 2'd0) ? crc_init : crc_r;
  assign wh_cur  = (head.start && step_r == 2'd0) ? seed_of(channel) : wh_r;
  assign is_data = head.keep && (step_r == 2'd0);
  assign k       = step_r - {1'b0, head.keep};

  always_comb begin
    unique case (k)
      2'd0:    crc_byte = crc_cur[23:16];
      2'd1:    crc_byte = crc_cur[15:8];
      default: crc_byte = crc_cur[7:0];
    endcase
    crc_nxt = crc_cur;
    if (is_data) begin
      crc_nxt = crc_feed(crc_cur, head.data);
      w       = whiten(wh_cur, head.data);
    end else begin
      w       = whiten(wh_cur, rev8(crc_byte));
    end
    enc_byte = rev8(w.data);
    done     = is_data ? !head.last : (k == 2'd2);
  end

  assign pop = adv && done;

  always_ff @(posedge clk) begin
    if (adv) begin
      crc_r      <= crc_nxt;
      wh_r       <= w.lfsr;
      byte_r     <= enc_byte;
      crc_flag_r <= !is_data;
      last_r     <= !is_data && (k == 2'd2);
      ovf_r      <= !is_data && head.ovf;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv) begin
        step_r      <= done ? 2'd0 : step_r + 2'd1;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_byte  = byte_r;
  assign out_crc   = crc_flag_r;
  assign out_last  = last_r;
  assign out_ovf   = ovf_r;

  a_last_is_crc: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && last_r |-> crc_flag_r)
    else $error("final beat is not a CRC byte");

  a_data_no_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !crc_flag_r |-> !ovf_r)
    else $error("overflow flagged on an emitted data byte");

  a_tail_only_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    q_valid && step_r != 2'd0 |-> head.last)
    else $error("CRC tail step on a command without last mark");

endmodule

@@ tb/blecw_encode_checker.sv @@
// Scoreboard for the BLE CRC-24 and whitening encoder: predicts every encoded beat and compares.
`timescale 1ns / 1ps

module blecw_encode_checker #(
  parameter int MAX_PACKET = blecw_pkg::MAX_PACKET_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [7:0]  in_tdata,
  input  logic        in_tlast,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  out_tdata,
  input  logic [1:0]  out_tuser,
  input  logic        out_tlast,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic        cfg_wr_en,
  input  logic [0:0]  cfg_index,
  input  logic [23:0] cfg_wdata,
  output int          fail_count,
  output int          outstanding
);
  import blecw_pkg::*;

  typedef struct packed {
    logic [7:0] code;
    logic       is_crc;
    logic       last;
    logic       ovf;
  } air_beat_t;

  air_beat_t   air_bytes_due[$];

  // Shadow copies of the configuration and of the running packet state.
  logic [5:0]  chan_cfg;
  logic [23:0] crc_seed_cfg;
  logic [23:0] crc_acc;
  logic [7:0]  lfsr;
  int          pkt_len;
  logic        pkt_dropped;

  initial begin
    fail_count  = 0;
    outstanding = 0;
  end

  function automatic logic [7:0] flip8(input logic [7:0] v);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[7-i] = v[i];
    end
    return r;
  endfunction

  function automatic void crc_absorb(input logic [7:0] d);
    logic fb;
    for (int i = 0; i < 8; i++) begin
      fb      = crc_acc[23] ^ d[i];
      crc_acc = {crc_acc[22:0], 1'b0} ^ (fb ? CRC_POLY : 24'h0);
    end
  endfunction

  // Advances the whitening LFSR by eight steps and returns the scrambled byte.
  function automatic logic [7:0] scramble(input logic [7:0] d);
    logic [7:0] r;
    r = d;
    for (int i = 0; i < 8; i++) begin
      if (lfsr[7]) begin
        lfsr = lfsr ^ WHITEN_TAPS;
        r[i] = ~r[i];
      end
      lfsr = {lfsr[6:0], 1'b0};
    end
    return r;
  endfunction

  task automatic encode_pdu_byte(input logic [7:0] d, input logic is_last);
    air_beat_t  beat;
    logic [23:0] crc_snap;
    if (pkt_len == 0) begin
      crc_acc = crc_seed_cfg;
      lfsr    = flip8({2'b00, chan_cfg}) | SEED_OR;
    end
    if (pkt_len < MAX_PACKET - 3) begin
      pkt_len++;
      crc_absorb(d);
      beat = '{code: flip8(scramble(d)), is_crc: 1'b0, last: 1'b0, ovf: pkt_dropped};
      air_bytes_due.push_back(beat);
    end else begin
      pkt_dropped = 1'b1;
    end
    if (is_last) begin
      crc_snap = crc_acc;
      for (int k = 0; k < 3; k++) begin
        beat = '{code: flip8(scramble(flip8(crc_snap[23-8*k -: 8]))), is_crc: 1'b1,
                 last: (k == 2), ovf: pkt_dropped};
        air_bytes_due.push_back(beat);
      end
      pkt_len     = 0;
      pkt_dropped = 1'b0;
    end
  endtask

  always @(posedge clk) begin
    air_beat_t want;
    if (!rst_n) begin
      chan_cfg     = CHANNEL_RESET;
      crc_seed_cfg = CRC_INIT_RESET;
      pkt_len      = 0;
      pkt_dropped  = 1'b0;
      air_bytes_due.delete();
    end else begin
      if (cfg_wr_en) begin
        if (cfg_index == REG_CHANNEL) begin
          chan_cfg = cfg_wdata[5:0];
        end else begin
          crc_seed_cfg = cfg_wdata;
        end
      end
      if (in_tvalid && in_tready) begin
        encode_pdu_byte(in_tdata, in_tlast);
      end
      if (out_tvalid && out_tready) begin
        if (air_bytes_due.size() == 0) begin
          $error("unexpected output beat: out_byte %0h", out_tdata);
          fail_count++;
        end else begin
          want = air_bytes_due.pop_front();
          if (out_tdata !== want.code) begin
            $error("out_byte: expected %0h, got %0h", want.code, out_tdata);
            fail_count++;
          end
          if (out_tuser[0] !== want.is_crc) begin
            $error("is_crc: expected %0b, got %0b", want.is_crc, out_tuser[0]);
            fail_count++;
          end
          if (out_tlast !== want.last) begin
            $error("last_out: expected %0b, got %0b", want.last, out_tlast);
            fail_count++;
          end
          if (out_tuser[1] !== want.ovf) begin
            $error("overflow: expected %0b, got %0b", want.ovf, out_tuser[1]);
            fail_count++;
          end
        end
      end
    end
    outstanding = air_bytes_due.size();
  end

endmodule

@@ tb/tb.sv @@
// Top-level testbench for the BLE advertising CRC-24 and whitening encoder.
`timescale 1ns / 1ps

module tb;
  import blecw_pkg::*;

  localparam int PKT_MAX         = MAX_PACKET_DEF;
  localparam int ITEMS_PER_PHASE = 105;
  // Margin for the encoder to answer a beat and finish its CRC tail.
  localparam int SETTLE          = 8;
  localparam int LONG_HOLD       = 80;
  localparam int DRAIN_LIMIT     = 20000;

  logic        clk;
  logic        rst_n      = 1'b0;
  // in_tdata: [7:0] data_byte
  logic [7:0]  in_tdata   = '0;
  logic        in_tlast   = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  // out_tdata: [7:0] out_byte
  logic [7:0]  out_tdata;
  // out_tuser: [0] is_crc, [1] overflow
  logic [1:0]  out_tuser;
  logic        out_tlast;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic        cfg_wr_en  = 1'b0;
  logic [0:0]  cfg_index  = '0;
  logic [23:0] cfg_wdata  = '0;

  int fail_count;
  int outstanding;

  // Percentages of cycles in which the sender idles and the receiver stalls.
  int send_idle  = 0;
  int recv_stall = 0;

  // The stimulus process flips hold_req to ask the receiver for one long hold-off;
  // the receiver process counts the stretch down on its own.
  logic hold_req  = 1'b0;
  logic hold_ack  = 1'b0;
  int   hold_left = 0;

  ble_adv_packet_crc_whiten_core #(
    .MAX_PACKET(PKT_MAX)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  blecw_encode_checker #(
    .MAX_PACKET(PKT_MAX)
  ) checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .outstanding(outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Safety net: a hung handshake ends the run here.
  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // Receiver: random stalls at the current rate, except during a long hold-off.
  always @(posedge clk) begin
    if (hold_req != hold_ack) begin
      hold_ack   <= hold_req;
      hold_left  <= LONG_HOLD;
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= recv_stall);
    end
  end

  // Offers one beat, after a random number of idle cycles, and returns at the edge
  // where it is taken. Valid stays high on return so back-to-back beats need no
  // extra cycle; whoever comes next either lowers it or offers the next beat.
  task automatic send_beat(input logic [7:0] d, input logic is_last);
    while ($urandom_range(0, 99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= d;
    in_tlast  <= is_last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Registers only change while the encoder is idle: every predicted beat must
  // have left, and the pipeline then waits out the SETTLE margin.
  task automatic load_setup(input logic [5:0] ch, input logic [23:0] init);
    logic [17:0] pad;
    pad = 18'($urandom);
    in_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (SETTLE) @(posedge clk);
    // Unused upper bits of the channel write carry noise; only [5:0] may count.
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_CHANNEL;
    cfg_wdata <= {pad, ch};
    @(posedge clk);
    cfg_index <= REG_CRC_INIT;
    cfg_wdata <= init;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Mostly random payload bytes, with the all-zero and all-one bytes favored.
  function automatic logic [7:0] payload_byte();
    int pick;
    pick = $urandom_range(0, 7);
    if (pick == 0) begin
      return 8'h00;
    end else if (pick == 1) begin
      return 8'hFF;
    end
    return 8'($urandom);
  endfunction

  // The first packets of each phase hit the length limit: the last byte taken
  // exactly at the limit, the last byte being the first one dropped, and a
  // packet that drops several bytes before its dropped last byte. After that,
  // mostly short packets with the odd overlong one.
  function automatic int packet_length(input int pkt);
    if (pkt == 0) begin
      return PKT_MAX - 3;
    end else if (pkt == 1) begin
      return PKT_MAX - 2;
    end else if (pkt == 2) begin
      return PKT_MAX + 3;
    end else if ($urandom_range(0, 9) == 0) begin
      return $urandom_range(PKT_MAX - 3, PKT_MAX + 6);
    end
    return $urandom_range(1, 12);
  endfunction

  initial begin
    int          counted;
    int          pkt;
    int          len;
    int          waited;
    logic [5:0]  ch;
    logic [23:0] init;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed packets under the reset configuration: one-byte packets at both
    // byte extremes, then a short packet with single-bit patterns.
    send_beat(8'h00, 1'b1);
    send_beat(8'hFF, 1'b1);
    send_beat(8'h00, 1'b0);
    send_beat(8'hFF, 1'b0);
    send_beat(8'h80, 1'b0);
    send_beat(8'h01, 1'b1);

    // Lowest channel with an all-zero CRC start, then the highest of both.
    load_setup(6'd0, 24'h000000);
    send_beat(8'hFF, 1'b0);
    send_beat(8'h00, 1'b1);
    load_setup(6'd63, 24'hFFFFFF);
    send_beat(8'h55, 1'b0);
    send_beat(8'hAA, 1'b1);

    // Random phases, each under its own idling pattern and configuration.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          ch = 6'd0;
          init = 24'h000000;
        end
        1: begin
          ch = 6'd63;
          init = 24'hFFFFFF;
        end
        2: begin
          ch = CHANNEL_RESET;
          init = CRC_INIT_RESET;
        end
        default: begin
          ch = 6'($urandom);
          init = 24'($urandom);
        end
      endcase
      load_setup(ch, init);

      case (ph)
        0: begin
          send_idle  = 0;
          recv_stall = 0;
        end
        1: begin
          send_idle  = 49;
          recv_stall = 0;
        end
        2: begin
          send_idle  = 0;
          recv_stall = 49;
        end
        default: begin
          send_idle  = 36;
          recv_stall = 36;
        end
      endcase

      // In the phase without idling or stalls the receiver backs off for a long stretch
      // while the sender streams a full-length packet, so the encoder's queue
      // fills and it must drop in_tready.
      if (ph == 0) begin
        hold_req <= ~hold_req;
      end

      counted = 0;
      pkt     = 0;
      while (counted < ITEMS_PER_PHASE) begin
        len = packet_length(pkt);
        for (int b = 0; b < len; b++) begin
          send_beat(payload_byte(), b == len - 1);
          // A dropped byte without the last mark emits no beat; it is not counted.
          if (b < PKT_MAX - 3 || b == len - 1) begin
            counted++;
          end
        end
        pkt++;
      end
    end

    // Drain: wait for every predicted beat, then a little longer so a stray
    // extra beat would still be caught.
    in_tvalid <= 1'b0;
    waited = 0;
    while (outstanding != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE * 2) @(posedge clk);

    if (fail_count == 0 && outstanding == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
